/* rtl/virtual_packet_segmenter_defines.svh */
// Assertion macros for the virtual packet segmenter.
// Depends on signals named clk and rst in the module that uses them.
`ifndef VIRTUAL_PACKET_SEGMENTER_DEFINES_SVH
`define VIRTUAL_PACKET_SEGMENTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vps_pkg.sv */
// Shared constants and codes for the virtual packet segmenter.
// No dependencies.
package vps_pkg;

  localparam int unsigned HEADER_BYTES      = 6;
  localparam int unsigned RAW_LEN_BITS_DEF  = 10;
  localparam int unsigned MAX_RAW_LEN_RESET = 250;
  localparam int unsigned APB_ADDR_BITS     = 3;
  localparam int unsigned APB_DATA_BITS     = 32;

  // Register byte addresses.
  localparam logic [APB_ADDR_BITS-1:0] REG_MAX_RAW_LEN = 3'd0;

  // Input command codes.
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Raw packet kinds.
  localparam logic KIND_CONT = 1'b0;
  localparam logic KIND_LAST = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_IDLE_DROP = 2'd1;
  localparam logic [1:0] STATUS_ABORT     = 2'd2;

  // Beat index of the last header byte.
  localparam logic [2:0] HDR_LAST_IDX = 3'(HEADER_BYTES - 1);

endpackage

/* rtl/virtual_packet_segmenter.sv */
// Virtual packet segmenter: cuts virtual packets into length-tagged raw packets.
// Depends on vps_pkg and virtual_packet_segmenter_defines.svh.
//
// Payload items pass at one per clock while out_ready is high: an input register, then
// a result register that the segment state updates with. A begin item yields six header
// beats, one per clock while out_ready is high; while they drain, one further item waits
// in the input register. The output beat rate of one per clock while out_ready is high,
// set by the single result register, is the limit.
// The raw length register (byte address 0) should be written only while the block is idle.
`include "virtual_packet_segmenter_defines.svh"

module virtual_packet_segmenter #(
  parameter int unsigned RAW_LEN_BITS = vps_pkg::RAW_LEN_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vps_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [vps_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [vps_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [31:0]                          packet_size,
  input  logic [15:0]                          packet_type,
  input  logic [7:0]                           payload_byte,
  // Output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_byte,
  output logic [RAW_LEN_BITS-1:0]              raw_len,
  output logic                                 raw_kind,
  output logic                                 raw_start,
  output logic                                 raw_end,
  output logic                                 virtual_end,
  output logic [1:0]                           status
);

  localparam logic [RAW_LEN_BITS-1:0] MaxRawLenReset =
    RAW_LEN_BITS'(vps_pkg::MAX_RAW_LEN_RESET);
  localparam logic [RAW_LEN_BITS-1:0] MinRawLen = RAW_LEN_BITS'(vps_pkg::HEADER_BYTES + 1);
  localparam logic [RAW_LEN_BITS-1:0] HdrLen    = RAW_LEN_BITS'(vps_pkg::HEADER_BYTES);

  // Configuration register
  logic [RAW_LEN_BITS-1:0] max_raw_len;

  // Input register
  logic        inq_valid;
  logic        inq_cmd;
  logic [31:0] inq_size;
  logic [15:0] inq_type;
  logic [7:0]  inq_byte;

  // Segment state; remaining counts payload bytes not yet sent.
  logic                    active, active_next;
  logic [31:0]             remaining, remaining_next;
  logic [RAW_LEN_BITS-1:0] left_in_raw, left_in_raw_next;
  logic [RAW_LEN_BITS-1:0] cur_len, cur_len_next;
  logic                    cur_kind, cur_kind_next;

  // Result register; header bytes shift out of the top of ob_data.
  logic                    ob_valid;
  logic [47:0]             ob_data, ob_data_next;
  logic [RAW_LEN_BITS-1:0] ob_len, ob_len_next;
  logic                    ob_kind, ob_kind_next;
  logic                    ob_start, ob_start_next;
  logic                    ob_end, ob_end_next;
  logic                    ob_vend, ob_vend_next;
  logic [1:0]              ob_status, ob_status_next;
  logic [2:0]              ob_idx;
  logic [2:0]              ob_last_idx, ob_last_idx_next;

  logic                    ob_final;
  logic                    advance;
  logic [RAW_LEN_BITS-1:0] eff_max;
  logic [RAW_LEN_BITS-1:0] room;
  logic                    fits_first;
  logic [RAW_LEN_BITS-1:0] first_len;
  logic [RAW_LEN_BITS-1:0] seg_len;
  logic                    seg_kind;
  logic                    seg_open;
  logic [RAW_LEN_BITS-1:0] left_dec;
  logic                    cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == vps_pkg::REG_MAX_RAW_LEN);
  assign prdata    = (paddr == vps_pkg::REG_MAX_RAW_LEN) ?
                     vps_pkg::APB_DATA_BITS'(max_raw_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_raw_len <= MaxRawLenReset;
    end else if (cfg_write) begin
      max_raw_len <= pwdata[RAW_LEN_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  assign ob_final = (ob_idx == ob_last_idx);
  assign advance  = inq_valid && (!ob_valid || (out_ready && ob_final));
  assign in_ready = !inq_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      inq_cmd  <= cmd;
      inq_size <= packet_size;
      inq_type <= packet_type;
      inq_byte <= payload_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Segmentation logic
  assign eff_max    = (max_raw_len < MinRawLen) ? MinRawLen : max_raw_len;
  assign room       = eff_max - HdrLen;
  assign fits_first = (inq_size <= 32'(room));
  assign first_len  = inq_size[RAW_LEN_BITS-1:0] + HdrLen;

  // A payload byte opens a new raw packet when the open one is used up.
  assign seg_open = (left_in_raw == '0);
  always_comb begin
    if (!seg_open) begin
      seg_len  = cur_len;
      seg_kind = cur_kind;
    end else if (remaining <= 32'(eff_max)) begin
      seg_len  = remaining[RAW_LEN_BITS-1:0];
      seg_kind = vps_pkg::KIND_LAST;
    end else begin
      seg_len  = eff_max;
      seg_kind = vps_pkg::KIND_CONT;
    end
  end
  assign left_dec = (seg_open ? seg_len : left_in_raw) - RAW_LEN_BITS'(1);

  always_comb begin
    active_next      = active;
    remaining_next   = remaining;
    left_in_raw_next = left_in_raw;
    cur_len_next     = cur_len;
    cur_kind_next    = cur_kind;
    ob_data_next     = '0;
    ob_len_next      = '0;
    ob_kind_next     = vps_pkg::KIND_CONT;
    ob_start_next    = 1'b0;
    ob_end_next      = 1'b0;
    ob_vend_next     = 1'b0;
    ob_status_next   = vps_pkg::STATUS_OK;
    ob_last_idx_next = '0;
    if (inq_cmd == vps_pkg::CMD_BEGIN) begin
      active_next      = (inq_size != '0);
      remaining_next   = inq_size;
      cur_len_next     = fits_first ? first_len : eff_max;
      cur_kind_next    = fits_first ? vps_pkg::KIND_LAST : vps_pkg::KIND_CONT;
      left_in_raw_next = fits_first ? inq_size[RAW_LEN_BITS-1:0] : room;
      ob_data_next     = {inq_size, inq_type};
      ob_len_next      = cur_len_next;
      ob_kind_next     = cur_kind_next;
      ob_start_next    = 1'b1;
      ob_end_next      = (inq_size == '0);
      ob_vend_next     = (inq_size == '0);
      ob_status_next   = active ? vps_pkg::STATUS_ABORT : vps_pkg::STATUS_OK;
      ob_last_idx_next = vps_pkg::HDR_LAST_IDX;
    end else if (!active) begin
      ob_status_next = vps_pkg::STATUS_IDLE_DROP;
    end else begin
      remaining_next   = remaining - 32'd1;
      cur_len_next     = seg_len;
      cur_kind_next    = seg_kind;
      left_in_raw_next = left_dec;
      ob_data_next     = {inq_byte, 40'd0};
      ob_len_next      = seg_len;
      ob_kind_next     = seg_kind;
      ob_start_next    = seg_open;
      ob_end_next      = (left_dec == '0);
      ob_vend_next     = (remaining == 32'd1);
      if (remaining == 32'd1) begin
        active_next      = 1'b0;
        left_in_raw_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      remaining   <= '0;
      left_in_raw <= '0;
      cur_len     <= '0;
      cur_kind    <= 1'b0;
      ob_valid    <= 1'b0;
      ob_idx      <= '0;
      ob_last_idx <= '0;
    end else if (advance) begin
      active      <= active_next;
      remaining   <= remaining_next;
      left_in_raw <= left_in_raw_next;
      cur_len     <= cur_len_next;
      cur_kind    <= cur_kind_next;
      ob_valid    <= 1'b1;
      ob_idx      <= '0;
      ob_last_idx <= ob_last_idx_next;
    end else if (ob_valid && out_ready) begin
      if (ob_final) begin
        ob_valid <= 1'b0;
      end else begin
        ob_idx <= ob_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ob_data   <= ob_data_next;
      ob_len    <= ob_len_next;
      ob_kind   <= ob_kind_next;
      ob_start  <= ob_start_next;
      ob_end    <= ob_end_next;
      ob_vend   <= ob_vend_next;
      ob_status <= ob_status_next;
    end else if (ob_valid && out_ready && !ob_final) begin
      ob_data <= {ob_data[39:0], 8'd0};
    end
  end

  // ---------------------------------------------------------------------------
  // Output beat
  assign out_valid   = ob_valid;
  assign out_byte    = ob_data[47:40];
  assign raw_len     = ob_len;
  assign raw_kind    = ob_kind;
  assign raw_start   = ob_start && (ob_idx == '0);
  assign raw_end     = ob_end && ob_final;
  assign virtual_end = ob_vend && ob_final;
  assign status      = ob_status;

  // ---------------------------------------------------------------------------
  // Assertions
  `VPS_ASSERT_SAME(a_vend_closes_raw, out_valid && virtual_end, raw_end, "virtual end without raw end")
  `VPS_ASSERT_SAME(a_active_has_bytes, active, remaining != '0, "active with no bytes remaining")
  `VPS_ASSERT_SAME(a_left_below_len, active, left_in_raw < cur_len, "open raw packet overrun")
  `VPS_ASSERT_SAME(a_multi_beat_is_hdr, ob_valid && !ob_final, ob_last_idx == vps_pkg::HDR_LAST_IDX, "multi-beat result that is not a header")
  `VPS_ASSERT_NEXT(a_advance_loads, advance, ob_valid && (ob_idx == '0), "result register not loaded")

endmodule
